### hw/rtl/irs_pkg.sv
// Shared types and constants for the image rotate sampler.
// Depends on nothing; the coordinate mapper and the top level import it.
package irs_pkg;

    // Defaults for the top-level parameters.
    localparam int SRC_PIXELS_DEF    = 65536;
    localparam int PALETTE_DEPTH_DEF = 256;
    localparam int MAX_OUT_DEF       = 512;

    // Fixed-point layout of the coordinate datapath.
    localparam int FRAC_BITS = 12;
    localparam int DELTA_W   = 12;
    localparam int TRIG_W    = 16;
    localparam int PROD_W    = DELTA_W + TRIG_W;
    localparam int COORD_W   = 32;

    // Configuration port.
    localparam int PADDR_W = 5;

    // Word actions.
    localparam logic [1:0] ACT_WR_PIXEL   = 2'd0;
    localparam logic [1:0] ACT_WR_PALETTE = 2'd1;
    localparam logic [1:0] ACT_RENDER     = 2'd2;

    // Register indexes (byte address divided by four).
    localparam logic [2:0] REG_COS    = 3'd0;
    localparam logic [2:0] REG_SIN    = 3'd1;
    localparam logic [2:0] REG_WIDTH  = 3'd2;
    localparam logic [2:0] REG_HEIGHT = 3'd3;
    localparam logic [2:0] REG_OUTSZ  = 3'd4;
    localparam logic [2:0] REG_TRANSP = 3'd5;

    // Payload of one input word as it travels down the pipeline.
    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] src_address;
        logic [7:0]  colour_index;
        logic [31:0] palette_word;
    } irs_item_t;

    // Settings the coordinate mapper needs.
    typedef struct packed {
        logic signed [TRIG_W-1:0] cos_scaled;
        logic signed [TRIG_W-1:0] sin_scaled;
        logic [7:0]               half_width;
        logic [7:0]               half_height;
    } irs_map_cfg_t;

endpackage

### hw/rtl/irs_if.sv
// Valid/ready channel interfaces for the image rotate sampler.
// Self-contained; used by the top level for its input and output ports.
interface irs_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [15:0] src_address;
    logic [7:0]  colour_index;
    logic [31:0] palette_word;
    logic [8:0]  out_x;
    logic [8:0]  out_y;

    modport source (
        output valid, action, src_address, colour_index, palette_word, out_x, out_y,
        input  ready
    );
    modport sink (
        input  valid, action, src_address, colour_index, palette_word, out_x, out_y,
        output ready
    );
endinterface

interface irs_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] pix_data;
    logic        mask_bit;

    modport source (
        output valid, pix_data, mask_bit,
        input  ready
    );
    modport sink (
        input  valid, pix_data, mask_bit,
        output ready
    );
endinterface

### hw/rtl/irs_map.sv
// Coordinate mapper: two pipeline stages that form the Q.12 source coordinates.
// Depends on irs_pkg for the item and settings types.
module irs_map (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  adv,
    input  logic                                  in_valid,
    input  irs_pkg::irs_item_t                    in_item,
    input  logic signed [irs_pkg::DELTA_W-1:0]    in_da,
    input  logic signed [irs_pkg::DELTA_W-1:0]    in_db,
    input  irs_pkg::irs_map_cfg_t                 cfg,
    output logic                                  out_valid,
    output irs_pkg::irs_item_t                    out_item,
    output logic signed [irs_pkg::COORD_W-1:0]    out_u,
    output logic signed [irs_pkg::COORD_W-1:0]    out_v
);
    import irs_pkg::*;

    logic                      a_valid_reg;
    irs_item_t                 a_item_reg;
    logic signed [PROD_W-1:0]  prod_ac_reg, prod_bs_reg, prod_as_reg, prod_bc_reg;
    logic signed [PROD_W-1:0]  prod_ac_next, prod_bs_next, prod_as_next, prod_bc_next;

    logic                      b_valid_reg;
    irs_item_t                 b_item_reg;
    logic signed [COORD_W-1:0] u_reg, v_reg;
    logic signed [COORD_W-1:0] u_next, v_next;
    logic signed [COORD_W-1:0] off_u, off_v;

    // Stage A: the four products of the rotation matrix.
    assign prod_ac_next = in_da * cfg.cos_scaled;
    assign prod_bs_next = in_db * cfg.sin_scaled;
    assign prod_as_next = in_da * cfg.sin_scaled;
    assign prod_bc_next = in_db * cfg.cos_scaled;

    // Stage B: u = da*co + db*si + d2*4096, v = db*co - da*si + d3*4096.
    assign off_u  = $signed({{(COORD_W-8-FRAC_BITS){1'b0}}, cfg.half_width,
                             {FRAC_BITS{1'b0}}});
    assign off_v  = $signed({{(COORD_W-8-FRAC_BITS){1'b0}}, cfg.half_height,
                             {FRAC_BITS{1'b0}}});
    assign u_next = COORD_W'(prod_ac_reg) + COORD_W'(prod_bs_reg) + off_u;
    assign v_next = COORD_W'(prod_bc_reg) - COORD_W'(prod_as_reg) + off_v;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_item_reg  <= in_item;
            prod_ac_reg <= prod_ac_next;
            prod_bs_reg <= prod_bs_next;
            prod_as_reg <= prod_as_next;
            prod_bc_reg <= prod_bc_next;
            b_item_reg  <= a_item_reg;
            u_reg       <= u_next;
            v_reg       <= v_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_item  = b_item_reg;
    assign out_u     = u_reg;
    assign out_v     = v_reg;

endmodule

### hw/rtl/image_rotate_sampler_unit.sv
// Image rotate sampler, top level: pipeline control, source and palette memories, APB port.
// Depends on irs_pkg, the channel interfaces in irs_if and the coordinate mapper irs_map.
// Throughput: one word per clock; the pipeline is one in-order chain of seven registers.
// The chain freezes only while a result sits unread in the output register and a render
// word waits right behind it. Reset clears valid bits and settings, not the memories.
module image_rotate_sampler_unit #(
    parameter int SRC_PIXELS    = irs_pkg::SRC_PIXELS_DEF,
    parameter int PALETTE_DEPTH = irs_pkg::PALETTE_DEPTH_DEF,
    parameter int MAX_OUT       = irs_pkg::MAX_OUT_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    irs_in_if.sink                       in_ch,
    irs_out_if.source                    out_ch,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [irs_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import irs_pkg::*;

    localparam int SRC_AW = $clog2(SRC_PIXELS);
    localparam int PAL_AW = $clog2(PALETTE_DEPTH);

    // ------------------------------------------------------------------
    // Configuration registers. Writes land in the APB access phase; the
    // port never waits. Only the low bits of each register are kept.
    // ------------------------------------------------------------------
    logic signed [15:0] cos_reg;
    logic signed [15:0] sin_reg;
    logic [8:0]         width_reg;
    logic [8:0]         height_reg;
    logic [9:0]         outsz_reg;
    logic [7:0]         transp_reg;
    logic               cfg_we;
    logic [2:0]         cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];
    assign cfg_we  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_reg    <= 16'sd4096;
            sin_reg    <= 16'sd0;
            width_reg  <= 9'd256;
            height_reg <= 9'd256;
            outsz_reg  <= 10'd363;
            transp_reg <= 8'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_COS:    cos_reg    <= $signed(pwdata[15:0]);
                REG_SIN:    sin_reg    <= $signed(pwdata[15:0]);
                REG_WIDTH:  width_reg  <= pwdata[8:0];
                REG_HEIGHT: height_reg <= pwdata[8:0];
                REG_OUTSZ:  outsz_reg  <= pwdata[9:0];
                REG_TRANSP: transp_reg <= pwdata[7:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_COS:    prdata = {16'b0, cos_reg};
            REG_SIN:    prdata = {16'b0, sin_reg};
            REG_WIDTH:  prdata = {23'b0, width_reg};
            REG_HEIGHT: prdata = {23'b0, height_reg};
            REG_OUTSZ:  prdata = {22'b0, outsz_reg};
            REG_TRANSP: prdata = {24'b0, transp_reg};
            default:    prdata = 32'b0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline advance. All stages move together. The chain holds only
    // when the output register is full and unread and the word in the last
    // stage is a render that would need that register; a write word there
    // can still drain, so the block keeps taking words behind it.
    // ------------------------------------------------------------------
    logic out_valid_reg;
    logic p6_valid_reg;
    logic p6_render_reg;
    logic adv;

    assign adv         = !out_valid_reg || out_ch.ready || !(p6_valid_reg && p6_render_reg);
    assign in_ch.ready = adv;

    // ------------------------------------------------------------------
    // Stage 1: register the word and form the centered offsets.
    // With s the clamped output side and d1 = s/2, the mapper needs
    // da = d1 - (s-1-x) and db = d1 - (s-1-y); both fit in DELTA_W bits.
    // ------------------------------------------------------------------
    logic [9:0]                side;
    logic [8:0]                half_side;
    logic signed [DELTA_W-1:0] delta_base;
    logic signed [DELTA_W-1:0] da_next, db_next;
    irs_item_t                 in_item;

    logic                      p1_valid_reg;
    irs_item_t                 p1_item_reg;
    logic signed [DELTA_W-1:0] p1_da_reg, p1_db_reg;

    assign side       = (12'(outsz_reg) > 12'(MAX_OUT)) ? 10'(MAX_OUT) : outsz_reg;
    assign half_side  = side[9:1];
    assign delta_base = $signed({3'b0, half_side}) - $signed({2'b0, side})
                        + $signed(DELTA_W'(1));
    assign da_next    = delta_base + $signed({3'b0, in_ch.out_x});
    assign db_next    = delta_base + $signed({3'b0, in_ch.out_y});

    assign in_item.action       = in_ch.action;
    assign in_item.src_address  = in_ch.src_address;
    assign in_item.colour_index = in_ch.colour_index;
    assign in_item.palette_word = in_ch.palette_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            p1_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_item_reg <= in_item;
            p1_da_reg   <= da_next;
            p1_db_reg   <= db_next;
        end
    end

    // ------------------------------------------------------------------
    // Stages 2 and 3: products and sums in the mapper.
    // ------------------------------------------------------------------
    irs_map_cfg_t              map_cfg;
    logic                      m_valid;
    irs_item_t                 m_item;
    logic signed [COORD_W-1:0] m_u, m_v;

    assign map_cfg.cos_scaled  = cos_reg;
    assign map_cfg.sin_scaled  = sin_reg;
    assign map_cfg.half_width  = width_reg[8:1];
    assign map_cfg.half_height = height_reg[8:1];

    irs_map u_map (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (p1_valid_reg),
        .in_item   (p1_item_reg),
        .in_da     (p1_da_reg),
        .in_db     (p1_db_reg),
        .cfg       (map_cfg),
        .out_valid (m_valid),
        .out_item  (m_item),
        .out_u     (m_u),
        .out_v     (m_v)
    );

    // ------------------------------------------------------------------
    // Stage 4: bounds check and row times width. A coordinate is inside
    // when it is not negative and its integer part is below the size;
    // the integer part then fits in nine bits.
    // ------------------------------------------------------------------
    logic       u_inside, v_inside;
    logic [8:0] col_next, row_next;
    logic [17:0] rowmul_next;

    logic        p4_valid_reg;
    irs_item_t   p4_item_reg;
    logic        p4_inb_reg;
    logic [8:0]  p4_col_reg;
    logic [17:0] p4_rowmul_reg;

    assign u_inside    = !m_u[COORD_W-1] &&
                         (m_u[COORD_W-1:FRAC_BITS] < (COORD_W-FRAC_BITS)'(width_reg));
    assign v_inside    = !m_v[COORD_W-1] &&
                         (m_v[COORD_W-1:FRAC_BITS] < (COORD_W-FRAC_BITS)'(height_reg));
    assign col_next    = m_u[FRAC_BITS+8:FRAC_BITS];
    assign row_next    = m_v[FRAC_BITS+8:FRAC_BITS];
    assign rowmul_next = row_next * width_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p4_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            p4_valid_reg <= m_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p4_item_reg   <= m_item;
            p4_inb_reg    <= u_inside && v_inside;
            p4_col_reg    <= col_next;
            p4_rowmul_reg <= rowmul_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: source pixel memory. Pixel writes and render reads both
    // happen here, so in-order words see each other exactly as issued and
    // a read never meets a write of another word in the same cycle.
    // ------------------------------------------------------------------
    logic [18:0]       addr_sum;
    logic [31:0]       rd_wide, wr_wide;
    logic [SRC_AW-1:0] src_rd_idx, src_wr_idx;
    logic              addr_ok;
    logic              src_we;

    logic [7:0]        src_mem [SRC_PIXELS];
    logic              p5_valid_reg;
    irs_item_t         p5_item_reg;
    logic              p5_ok_reg;
    logic [7:0]        src_rd_reg;

    assign addr_sum   = {1'b0, p4_rowmul_reg} + {10'b0, p4_col_reg};
    assign rd_wide    = {13'b0, addr_sum};
    assign wr_wide    = {16'b0, p4_item_reg.src_address};
    assign src_rd_idx = rd_wide[SRC_AW-1:0];
    assign src_wr_idx = wr_wide[SRC_AW-1:0];
    assign addr_ok    = p4_inb_reg && (rd_wide < 32'(SRC_PIXELS));
    assign src_we     = p4_valid_reg && (p4_item_reg.action == ACT_WR_PIXEL) &&
                        (wr_wide < 32'(SRC_PIXELS));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (src_we)
            begin
                src_mem[src_wr_idx] <= p4_item_reg.colour_index;
            end
            src_rd_reg <= src_mem[src_rd_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p5_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            p5_valid_reg <= p4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p5_item_reg <= p4_item_reg;
            p5_ok_reg   <= addr_ok;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: palette memory, same arrangement as the source memory. An
    // index past the palette gives a zero word but still drives the mask.
    // ------------------------------------------------------------------
    logic              pal_idx_ok;
    logic              pal_we;
    logic [PAL_AW-1:0] pal_rd_idx, pal_wr_idx;

    logic [31:0]       pal_mem [PALETTE_DEPTH];
    logic [31:0]       pal_rd_reg;
    logic              p6_pix_ok_reg;
    logic              p6_mask_reg;

    assign pal_idx_ok = {24'b0, src_rd_reg} < 32'(PALETTE_DEPTH);
    assign pal_rd_idx = src_rd_reg[PAL_AW-1:0];
    assign pal_wr_idx = p5_item_reg.colour_index[PAL_AW-1:0];
    assign pal_we     = p5_valid_reg && (p5_item_reg.action == ACT_WR_PALETTE) &&
                        ({24'b0, p5_item_reg.colour_index} < 32'(PALETTE_DEPTH));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (pal_we)
            begin
                pal_mem[pal_wr_idx] <= p5_item_reg.palette_word;
            end
            pal_rd_reg <= pal_mem[pal_rd_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p6_valid_reg  <= 1'b0;
            p6_render_reg <= 1'b0;
        end
        else if (adv)
        begin
            p6_valid_reg  <= p5_valid_reg;
            p6_render_reg <= (p5_item_reg.action == ACT_RENDER);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p6_pix_ok_reg <= p5_ok_reg && pal_idx_ok;
            p6_mask_reg   <= p5_ok_reg && (src_rd_reg != transp_reg);
        end
    end

    // ------------------------------------------------------------------
    // Output register. Only render words load it; it empties when read.
    // ------------------------------------------------------------------
    logic        out_load;
    logic        out_valid_next;
    logic [31:0] out_pixel_reg;
    logic        out_mask_reg;

    assign out_load = adv && p6_valid_reg && p6_render_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ch.ready;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_pixel_reg <= p6_pix_ok_reg ? pal_rd_reg : 32'b0;
            out_mask_reg  <= p6_mask_reg;
        end
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.pix_data = out_pixel_reg;
    assign out_ch.mask_bit = out_mask_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    // Input is refused only while an unread result blocks the last stage.
    a_ready_only_when_blocked: assert property (
        @(posedge clk) disable iff (!rst_n)
        !in_ch.ready |-> (out_valid_reg && !out_ch.ready)
    ) else $error("input refused without a blocked output");

    // A render leaving the last stage always lands in the output register.
    a_render_reaches_output: assert property (
        @(posedge clk) disable iff (!rst_n)
        (adv && p6_valid_reg && p6_render_reg) |=> out_valid_reg
    ) else $error("render word lost at the output register");

    // The output register only fills from a render word.
    a_output_from_render: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(p6_valid_reg && p6_render_reg)
    ) else $error("result appeared without a render word");

endmodule
